/* sv/dad_pkg.sv */
package dad_pkg;

    localparam int MAX_YEAR_DEF = 9999;
    localparam int IN_YEAR_W    = 14;
    localparam int LEAP_CYCLE   = 400;
    localparam int REDUCE_STEPS = 6;
    localparam int STEP_W       = $clog2(REDUCE_STEPS);
    localparam int DAY_SUM_W    = 18;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [4:0] MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic              load;
        logic              reduce;
        logic [STEP_W-1:0] step;
        logic              check;
        logic              walk;
        logic              emit;
    } cmd_t;

    typedef struct packed {
        logic start_ok;
        logic walk_done;
        logic walk_fail;
    } stat_t;

    // rem is the year modulo 400
    function automatic logic is_leap(input logic [8:0] rem);
        logic century;
        century = (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
        return (rem[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        if (mon == 4'd0 || mon > MON_DEC)
            len = 5'd31;
        else if (leap && mon == MON_FEB)
            len = 5'd29;
        else
            len = MONTH_LEN[mon];
        return len;
    endfunction

endpackage

/* sv/date_add_days.sv */
// Gregorian date plus a signed day offset.
// Input stream s_axis: one transfer carries a start date and an offset.
// Output stream m_axis: one transfer per input with the shifted date; tuser
// is high when the result is valid, low when the start date was invalid or
// the result year left 0..MAX_YEAR (the start date is then echoed).
// Per item the block accepts the transfer, reduces the year modulo 400 by
// shift-subtract, checks the start date, then crosses one month boundary per
// cycle until the day fits in its month or the year leaves the range, and
// loads the output register. The month walk through the current and previous
// month-length lookups sets the rate; one item is in work at a time.
// The output register holds a finished result while the next item is
// accepted and walked; if m_axis_tready stays low, the block waits with
// its next result until the register drains and s_axis_tready stays low.
// Reset clears the controller and the output valid; nothing else needs it.
module date_add_days
    import dad_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], offset_days[39:23]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_year[13:0], result_month[17:14], result_day[22:18], zero pad[23]
    output logic [23:0] m_axis_tdata,
    // date_ok[0]
    output logic        m_axis_tuser
);

    cmd_t  cmd;
    stat_t stat;

    logic [IN_YEAR_W-1:0] result_year;
    logic [3:0]           result_month;
    logic [4:0]           result_day;

    dad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dad_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .stat         (stat),
        .start_year   (s_axis_tdata[13:0]),
        .start_month  (s_axis_tdata[17:14]),
        .start_day    (s_axis_tdata[22:18]),
        .offset_days  ($signed(s_axis_tdata[39:23])),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .date_ok      (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, result_day, result_month, result_year};

endmodule

/* sv/dad_ctrl.sv */
module dad_ctrl
    import dad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = cnt_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = STEP_W'(REDUCE_STEPS - 1);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_CHECK;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.start_ok ? ST_WALK : ST_EMIT;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done || stat.walk_fail)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // output register frees up either empty or drained this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* sv/dad_dp.sv */
module dad_dp
    import dad_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
)
(
    input  logic                  clk,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [IN_YEAR_W-1:0]  start_year,
    input  logic [3:0]            start_month,
    input  logic [4:0]            start_day,
    input  logic signed [16:0]    offset_days,
    output logic [IN_YEAR_W-1:0]  result_year,
    output logic [3:0]            result_month,
    output logic [4:0]            result_day,
    output logic                  date_ok
);

    localparam int YEAR_W = ($clog2(MAX_YEAR + 1) > IN_YEAR_W) ?
                            $clog2(MAX_YEAR + 1) : IN_YEAR_W;
    localparam logic [YEAR_W-1:0]    YEAR_LIMIT = YEAR_W'(MAX_YEAR);
    localparam logic [IN_YEAR_W-1:0] REM_TOP    = IN_YEAR_W'(LEAP_CYCLE - 1);

    logic [IN_YEAR_W-1:0]        sy_reg;
    logic [3:0]                  sm_reg;
    logic [4:0]                  sd_reg;
    logic [YEAR_W-1:0]           y_reg;
    logic [3:0]                  m_reg;
    logic signed [DAY_SUM_W-1:0] d_reg;
    logic [IN_YEAR_W-1:0]        rem_reg;
    logic                        ok_reg;

    logic [IN_YEAR_W-1:0]        res_year_reg;
    logic [3:0]                  res_month_reg;
    logic [4:0]                  res_day_reg;
    logic                        res_ok_reg;

    logic [IN_YEAR_W-1:0]        chunk;
    logic [4:0]                  dim_cur, dim_prev;
    logic                        fwd, bwd, wrap_fwd, wrap_bwd;
    logic [3:0]                  m_fwd, m_bwd;
    logic [IN_YEAR_W-1:0]        rem_fwd, rem_bwd;
    logic [3:0]                  m_bwd_sel;
    logic [IN_YEAR_W-1:0]        rem_bwd_sel;
    logic signed [DAY_SUM_W-1:0] d_start;

    assign d_start = $signed({{(DAY_SUM_W-5){1'b0}}, start_day})
                   + DAY_SUM_W'(offset_days);

    assign chunk = IN_YEAR_W'(LEAP_CYCLE) << cmd.step;

    assign dim_cur  = days_in_month(m_reg, is_leap(rem_reg[8:0]));
    assign wrap_fwd = (m_reg == MON_DEC);
    assign wrap_bwd = (m_reg == MON_JAN);
    assign m_fwd    = wrap_fwd ? MON_JAN : m_reg + 4'd1;
    assign m_bwd    = wrap_bwd ? MON_DEC : m_reg - 4'd1;
    assign rem_fwd  = (rem_reg == REM_TOP) ? '0 : rem_reg + 1'b1;
    assign rem_bwd  = (rem_reg == '0) ? REM_TOP : rem_reg - 1'b1;

    assign m_bwd_sel   = m_bwd;
    assign rem_bwd_sel = wrap_bwd ? rem_bwd : rem_reg;
    assign dim_prev    = days_in_month(m_bwd_sel, is_leap(rem_bwd_sel[8:0]));

    assign fwd = d_reg > $signed({{(DAY_SUM_W-5){1'b0}}, dim_cur});
    assign bwd = d_reg[DAY_SUM_W-1] || (d_reg == '0);

    always_comb
    begin
        stat.start_ok  = (YEAR_W'(sy_reg) <= YEAR_LIMIT) &&
                         (m_reg >= MON_JAN) && (m_reg <= MON_DEC) &&
                         (sd_reg != 5'd0) && (sd_reg <= dim_cur);
        stat.walk_done = !fwd && !bwd;
        stat.walk_fail = (fwd && wrap_fwd && (y_reg == YEAR_LIMIT)) ||
                         (bwd && wrap_bwd && (y_reg == '0));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sy_reg  <= start_year;
            sm_reg  <= start_month;
            sd_reg  <= start_day;
            y_reg   <= YEAR_W'(start_year);
            m_reg   <= start_month;
            d_reg   <= d_start;
            rem_reg <= start_year;
        end
        if (cmd.reduce && rem_reg >= chunk)
            rem_reg <= rem_reg - chunk;
        if (cmd.check)
            ok_reg <= stat.start_ok;
        if (cmd.walk)
        begin
            if (stat.walk_fail)
                ok_reg <= 1'b0;
            else if (fwd)
            begin
                d_reg <= d_reg - $signed({{(DAY_SUM_W-5){1'b0}}, dim_cur});
                m_reg <= m_fwd;
                if (wrap_fwd)
                begin
                    y_reg   <= y_reg + 1'b1;
                    rem_reg <= rem_fwd;
                end
            end
            else if (bwd)
            begin
                d_reg   <= d_reg + $signed({{(DAY_SUM_W-5){1'b0}}, dim_prev});
                m_reg   <= m_bwd_sel;
                rem_reg <= rem_bwd_sel;
                if (wrap_bwd)
                    y_reg <= y_reg - 1'b1;
            end
        end
        if (cmd.emit)
        begin
            res_ok_reg <= ok_reg;
            if (ok_reg)
            begin
                res_year_reg  <= y_reg[IN_YEAR_W-1:0];
                res_month_reg <= m_reg;
                res_day_reg   <= d_reg[4:0];
            end
            else
            begin
                res_year_reg  <= sy_reg;
                res_month_reg <= sm_reg;
                res_day_reg   <= sd_reg;
            end
        end
    end

    assign result_year  = res_year_reg;
    assign result_month = res_month_reg;
    assign result_day   = res_day_reg;
    assign date_ok      = res_ok_reg;

endmodule

/* sv/dad_checker.sv */
module dad_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // reset empties the output register at once
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // a valid result always names a month from 1 to 12 and a nonzero day, pad bit clear
    a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[17:14] != 4'd0) && (m_axis_tdata[17:14] <= 4'd12) &&
            (m_axis_tdata[22:18] != 5'd0) && !m_axis_tdata[23])
        else $error("bad date on output");

    // one item in work: input closes right after a transfer
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped while stalled");

endmodule

bind date_add_days dad_checker u_dad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* sim/tb_date_add_days.sv */
module tb_date_add_days;
    import dad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 250;
    localparam int IDLE_PCT     = 19;
    // Budget for the whole run: the slowest walks, gaps, stalls and margin.
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic signed [16:0] days;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
    } date_req_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_res_t;

    class date_scoreboard;
        date_res_t shifted_dates[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int month_length(int y, int m);
            bit leap;
            if (m < 1 || m > 12)
                return 31;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            if (m == MON_FEB)
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        function date_res_t shift_date(date_req_t r);
            int        y;
            int        m;
            int        d;
            bit        ok;
            date_res_t res;
            y  = r.year;
            m  = r.month;
            d  = r.day;
            ok = 1'b1;
            if (y > MAX_YEAR_DEF || m < 1 || m > 12 || d < 1 || d > month_length(y, m))
            begin
                ok = 1'b0;
            end
            else
            begin
                d += int'($signed(r.days));
                while (ok && d > month_length(y, m))
                begin
                    d -= month_length(y, m);
                    m++;
                    if (m > 12)
                    begin
                        m = 1;
                        y++;
                        if (y > MAX_YEAR_DEF)
                            ok = 1'b0;
                    end
                end
                while (ok && d <= 0)
                begin
                    m--;
                    if (m == 0)
                    begin
                        m = 12;
                        y--;
                        if (y < 0)
                            ok = 1'b0;
                    end
                    if (ok)
                        d += month_length(y, m);
                end
            end
            if (ok)
            begin
                res.year  = y[13:0];
                res.month = m[3:0];
                res.day   = d[4:0];
                res.ok    = 1'b1;
            end
            else
            begin
                res.year  = r.year;
                res.month = r.month;
                res.day   = r.day;
                res.ok    = 1'b0;
            end
            return res;
        endfunction

        function void note_input(date_req_t r);
            shifted_dates.push_back(shift_date(r));
        endfunction

        function void check_result(date_res_t got);
            date_res_t want;
            if (shifted_dates.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected transfer: %0d-%0d-%0d ok=%0b",
                             got.year, got.month, got.day, got.ok);
                mismatches++;
                return;
            end
            want = shifted_dates.pop_front();
            if (got.year !== want.year || got.month !== want.month ||
                got.day !== want.day || got.ok !== want.ok)
            begin
                if (mismatches < REPORT_MAX)
                    $display("mismatch: expected %0d-%0d-%0d ok=%0b, got %0d-%0d-%0d ok=%0b",
                             want.year, want.month, want.day, want.ok,
                             got.year, got.month, got.day, got.ok);
                mismatches++;
            end
        endfunction

        function int pending();
            return shifted_dates.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    date_scoreboard sb;
    bit             steady;
    int             cycle_count;

    date_add_days u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic date_req_t mk_date(int y, int m, int d, int off);
        date_req_t r;
        r.year  = y[13:0];
        r.month = m[3:0];
        r.day   = d[4:0];
        r.days  = off[16:0];
        return r;
    endfunction

    function automatic date_req_t make_random_item();
        date_req_t r;
        int        kind;
        int        y;
        int        m;
        int        off;
        kind = $urandom_range(0, 99);
        m    = $urandom_range(1, 12);
        y    = $urandom_range(0, MAX_YEAR_DEF);
        if (kind < 60)
            off = int'($urandom_range(0, 1600)) - 800;
        else
            off = int'($urandom_range(0, 131070)) - 65535;
        // push toward either end of the year range
        if (kind >= 75 && kind < 85)
        begin
            if ($urandom_range(0, 1))
                y = MAX_YEAR_DEF - int'($urandom_range(0, 150));
            else
                y = $urandom_range(0, 150);
        end
        r = mk_date(y, m, $urandom_range(1, sb.month_length(y, m)), off);
        // raw fields: mostly malformed dates, every bit of every field
        if (kind >= 85)
            r = date_req_t'({$urandom, $urandom});
        return r;
    endfunction

    task automatic send_item(input date_req_t r);
        while (take_gap())
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = r;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(r);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        m_axis_tready = rst_n && !take_gap();
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(date_res_t'({m_axis_tuser, m_axis_tdata[22:0]}));
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        sb            = new();
        steady        = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero offset, year limits, leap rules, invalid fields, full offsets
        send_item(mk_date(2024, 1, 1, 0));
        send_item(mk_date(9999, 12, 31, 0));
        send_item(mk_date(0, 1, 1, 0));
        send_item(mk_date(9999, 12, 31, 1));
        send_item(mk_date(0, 1, 1, -1));
        send_item(mk_date(9998, 12, 31, 1));
        send_item(mk_date(2000, 2, 28, 1));
        send_item(mk_date(1900, 2, 28, 1));
        send_item(mk_date(0, 3, 1, -1));
        send_item(mk_date(2024, 3, 1, -1));
        send_item(mk_date(2024, 2, 29, 365));
        send_item(mk_date(2023, 2, 29, 1));
        send_item(mk_date(2024, 13, 1, 1));
        send_item(mk_date(2024, 0, 1, 1));
        send_item(mk_date(2024, 15, 31, -1));
        send_item(mk_date(2024, 4, 0, 1));
        send_item(mk_date(2024, 4, 31, 1));
        send_item(mk_date(2024, 1, 31, 1));
        send_item(mk_date(10000, 1, 1, 0));
        send_item(mk_date(16383, 6, 15, 5));
        send_item(mk_date(2000, 1, 1, 65535));
        send_item(mk_date(2000, 1, 1, -65535));
        send_item(mk_date(100, 1, 1, -65535));
        send_item(mk_date(9999, 12, 31, -65535));

        // hold the sender until the block has drained
        s_axis_tvalid = 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 100 && n < 150);
            send_item(make_random_item());
        end
        steady        = 1'b0;
        s_axis_tvalid = 1'b0;
        wait_drained();
        repeat (20) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
